>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/ircr_pkg.sv
// Types and constants of the infrared chunk reassembler.
package ircr_pkg;

	localparam int CHUNK_COUNT  = 4;
	localparam int CHUNK_BYTES  = 3;
	localparam int PACKET_BYTES = CHUNK_COUNT * CHUNK_BYTES;

	localparam logic [7:0]  HEADER_MASK   = 8'hFC;
	localparam logic [3:0]  FULL_MASK     = 4'hF;
	localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [5:0]  PREFIX_RESET  = 6'd0;

	// register indexes on the configuration port
	localparam logic REG_FRAME_PREFIX = 1'b0;
	localparam logic REG_TIMEOUT_MS   = 1'b1;

	// item opcodes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] frame_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic [3:0] byte_index;
		logic       last;
	} out_item_t;

endpackage

>>> hw/rtl/ir_chunk_reassembler.sv
// Infrared chunk reassembler: rebuilds 12-byte packets from four 3-byte frames.
//
// Input channel (in_valid/in_ready/in_item): each item is a received frame or a
// one-millisecond tick. Every item is handled in the cycle it is accepted; the
// timer, chunk mask and assembly bytes update at that edge, so one item can be
// accepted every cycle while in_ready is high.
// Output channel (out_valid/out_ready/out_item): a completed packet is copied
// into an output buffer and sent as twelve items, byte 0 first, the cycle after
// the completing frame is accepted, one item per cycle while out_ready is high.
// Throughput is set by that 12-deep output buffer: ticks and frames that do not
// complete a packet are always taken, while a frame that completes a packet
// waits (in_ready low) until the previous packet's last byte is taken.
// A stalled receiver simply holds the current byte; nothing is dropped.
// Configuration (cfg_we/cfg_index/cfg_data) writes the prefix or the timeout,
// with no read-back.
// Reset clears the chunk mask, timer and output buffer state, sets the prefix
// to 0 and the timeout to 500 ticks. No clearing pass is needed.
module ir_chunk_reassembler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ircr_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ircr_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

`include "assert_macros.svh"

	localparam logic [3:0] LAST_INDEX = 4'(ircr_pkg::PACKET_BYTES - 1);

	logic [5:0]  prefix_q;
	logic [15:0] timeout_q;
	logic [3:0]  mask_q;
	logic [15:0] timer_q;
	logic [7:0]  asm_q [ircr_pkg::PACKET_BYTES];
	logic [7:0]  pkt_q [ircr_pkg::PACKET_BYTES];
	logic [3:0]  idx_q;
	logic        busy_q;

	logic        in_acc;
	logic        out_acc;
	logic        last_out;
	logic        is_frame;
	logic        match;
	logic [1:0]  chunk;
	logic [3:0]  mask_eff;
	logic [3:0]  mask_new;
	logic        done;
	logic [7:0]  merged [ircr_pkg::PACKET_BYTES];
	logic [7:0]  header;

	assign header   = in_item.frame_word[31:24];
	assign is_frame = (in_item.op == ircr_pkg::OP_FRAME);
	assign match    = ((header & ircr_pkg::HEADER_MASK) == {prefix_q, 2'b00});
	assign chunk    = header[1:0];

	always_comb begin
		// timeout drop happens before the header check
		if (mask_q != 4'd0 && timer_q >= timeout_q) begin
			mask_eff = 4'd0;
		end else begin
			mask_eff = mask_q;
		end
		if (chunk == 2'd0) begin
			mask_new = 4'(1) << chunk;
		end else begin
			mask_new = mask_eff | (4'(1) << chunk);
		end
	end

	assign done     = is_frame && match && (mask_new == ircr_pkg::FULL_MASK);
	assign last_out = (idx_q == LAST_INDEX);
	assign out_acc  = out_valid && out_ready;
	assign in_ready = !busy_q || !done || (out_ready && last_out);
	assign in_acc   = in_valid && in_ready;

	// packet as it stands after this frame's bytes are written
	for (genvar k = 0; k < ircr_pkg::PACKET_BYTES; k++) begin : g_merge
		localparam logic [1:0] SLOT = 2'(k / ircr_pkg::CHUNK_BYTES);
		localparam int         LANE = 2 - (k % ircr_pkg::CHUNK_BYTES);
		assign merged[k] = (chunk == SLOT) ? in_item.frame_word[LANE*8 +: 8] : asm_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q  <= ircr_pkg::PREFIX_RESET;
			timeout_q <= ircr_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ircr_pkg::REG_FRAME_PREFIX: prefix_q  <= cfg_data[5:0];
				ircr_pkg::REG_TIMEOUT_MS:   timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= 4'd0;
			timer_q <= 16'd0;
		end else if (in_acc) begin
			if (!is_frame) begin
				if (timer_q != ircr_pkg::TIMER_MAX) begin
					timer_q <= timer_q + 16'd1;
				end
			end else if (!match) begin
				mask_q <= mask_eff;
			end else begin
				mask_q  <= done ? 4'd0 : mask_new;
				timer_q <= 16'd0;
			end
		end
	end

	// assembly bytes: written a chunk at a time, no reset
	always_ff @(posedge clk) begin
		if (in_acc && is_frame && match) begin
			for (int k = 0; k < ircr_pkg::PACKET_BYTES; k++) begin
				asm_q[k] <= merged[k];
			end
		end
	end

	// output buffer shifts toward entry 0 as bytes are taken
	always_ff @(posedge clk) begin
		if (in_acc && done) begin
			for (int k = 0; k < ircr_pkg::PACKET_BYTES; k++) begin
				pkt_q[k] <= merged[k];
			end
		end else if (out_acc) begin
			for (int k = 0; k < ircr_pkg::PACKET_BYTES - 1; k++) begin
				pkt_q[k] <= pkt_q[k + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (in_acc && done) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd0;
		end else if (out_acc) begin
			if (last_out) begin
				busy_q <= 1'b0;
				idx_q  <= 4'd0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	assign out_valid            = busy_q;
	assign out_item.packet_byte = pkt_q[0];
	assign out_item.byte_index  = idx_q;
	assign out_item.last        = last_out;

	`ASSERT_NEVER(a_idx_range, busy_q && idx_q > LAST_INDEX, "byte index past end of packet")
	`ASSERT_NEVER(a_mask_not_full, mask_q == ircr_pkg::FULL_MASK, "full chunk mask left stored")
	`ASSERT_AT(a_load_starts, in_acc && done |=> busy_q && idx_q == 4'd0, "packet load did not restart run")
	`ASSERT_AT(a_no_overrun, in_acc && done && busy_q |-> out_acc && last_out, "packet loaded over a pending run")
	`ASSERT_AT(a_timer_restart, in_acc && is_frame && match |=> timer_q == 16'd0, "timer not restarted by chunk")

endmodule
